### design/iit_pkg.sv
// Types, constants and butterfly functions for the 4x4 inverse integer transform.
// No dependencies; every other design file imports this package.
`default_nettype none

package iit_pkg;

    // Width of intermediate row and column pass values (legal range 12..32)
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_W       = 16;
    localparam int OUT_W        = 12;
    localparam int SUM_W        = SAMPLE_WIDTH + 2;
    localparam int ROUND_ADD    = 32;
    localparam int ROUND_SHIFT  = 6;
    localparam int ROWS         = 4;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t [3:0]                  quad_t;
    typedef quad_t [ROWS-1:0]               block_t;
    typedef logic signed [OUT_W-1:0]        resid_val_t;
    typedef resid_val_t [3:0]               resid_quad_t;
    typedef logic [1:0]                     row_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_col0;
        logic signed [COEF_W-1:0] coef_col1;
        logic signed [COEF_W-1:0] coef_col2;
        logic signed [COEF_W-1:0] coef_col3;
    } coef_row_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] resid_col0;
        logic signed [OUT_W-1:0] resid_col1;
        logic signed [OUT_W-1:0] resid_col2;
        logic signed [OUT_W-1:0] resid_col3;
        logic                    row_last;
    } resid_row_t;

    // Status of the block queue, seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam row_idx_t LAST_ROW = row_idx_t'(ROWS - 1);

    // Bring a 16-bit coefficient to sample width (wrap or sign-extend)
    function automatic sample_t to_sample(logic signed [COEF_W-1:0] x);
        logic signed [31:0] w;
        w = 32'(x);
        return w[SAMPLE_WIDTH-1:0];
    endfunction

    // Shared butterfly with half-weight odd terms, wrapping to sample width
    function automatic quad_t butterfly(quad_t a);
        sample_t a0, a1, a2, a3;
        quad_t   t;
        a0 = a[0];
        a1 = a[1];
        a2 = a[2];
        a3 = a[3];
        t[0] = a0 + a2;
        t[1] = a0 - a2;
        t[2] = (a1 >>> 1) - a3;
        t[3] = a1 + (a3 >>> 1);
        return t;
    endfunction

    // Horizontal pass over one row
    function automatic quad_t row_pass(quad_t a);
        quad_t   t;
        quad_t   r;
        sample_t t0, t1, t2, t3;
        t = butterfly(a);
        t0 = t[0];
        t1 = t[1];
        t2 = t[2];
        t3 = t[3];
        r[0] = t0 + t3;
        r[1] = t1 + t2;
        r[2] = t1 - t2;
        r[3] = t0 - t3;
        return r;
    endfunction

    // Round a full-width column sum: (+32) >>> 6, keep the output width
    function automatic resid_val_t round_out(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        sh = (s + SUM_W'(ROUND_ADD)) >>> ROUND_SHIFT;
        return sh[OUT_W-1:0];
    endfunction

    // Vertical pass over one column, one result per output row
    function automatic resid_quad_t col_pass(quad_t c);
        quad_t       t;
        resid_quad_t r;
        sample_t     t0, t1, t2, t3;
        t = butterfly(c);
        t0 = t[0];
        t1 = t[1];
        t2 = t[2];
        t3 = t[3];
        r[0] = round_out(SUM_W'(t0) + SUM_W'(t3));
        r[1] = round_out(SUM_W'(t1) + SUM_W'(t2));
        r[2] = round_out(SUM_W'(t1) - SUM_W'(t2));
        r[3] = round_out(SUM_W'(t0) - SUM_W'(t3));
        return r;
    endfunction

endpackage

`default_nettype wire

### design/iit_front.sv
// Front end: takes coefficient rows, runs the row pass and gathers a block.
// Depends on iit_pkg; pushes completed blocks into iit_queue.
`default_nettype none

module iit_front import iit_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      coef_valid,
    output logic           coef_stall,
    input  wire coef_row_t coef,
    input  wire q_status_t q_status,
    output logic           push,
    output block_t         push_data
);

    row_idx_t  rows_received_reg;
    row_idx_t  rows_received_next;
    quad_t [ROWS-2:0] row_store_reg;
    quad_t     in_quad;
    quad_t     rp;
    logic      take;

    // Hold the fourth row back while the queue has no room
    assign coef_stall = (rows_received_reg == LAST_ROW) && q_status.full;
    assign take       = coef_valid && !coef_stall;

    // Row pass on the incoming word
    always_comb
    begin
        in_quad[0] = to_sample(coef.coef_col0);
        in_quad[1] = to_sample(coef.coef_col1);
        in_quad[2] = to_sample(coef.coef_col2);
        in_quad[3] = to_sample(coef.coef_col3);
        rp = row_pass(in_quad);
    end

    // Assemble the block from the three kept rows and the current one
    always_comb
    begin
        push_data[ROWS-1] = rp;
        for (int i = 0; i < ROWS - 1; i++)
        begin
            push_data[i] = row_store_reg[i];
        end
        push = take && (rows_received_reg == LAST_ROW);
    end

    // Advance the row count
    always_comb
    begin
        rows_received_next = rows_received_reg;
        if (take)
        begin
            rows_received_next = rows_received_reg + row_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_received_reg <= '0;
        end
        else
        begin
            rows_received_reg <= rows_received_next;
        end
    end

    // Keep rows one to three
    always_ff @(posedge clk)
    begin
        if (take && (rows_received_reg != LAST_ROW))
        begin
            row_store_reg[rows_received_reg] <= rp;
        end
    end

endmodule

`default_nettype wire

### design/iit_queue.sv
// Two-entry block queue between the row pass and the column pass.
// Depends on iit_pkg.
`default_nettype none

module iit_queue import iit_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire block_t push_data,
    input  wire logic   pop,
    output block_t      head,
    output q_status_t   q_status
);

    block_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/iit_back.sv
// Back end: column pass over the head block, one output row per cycle while resid_stall is low.
// Depends on iit_pkg; pops blocks from iit_queue.
`default_nettype none

module iit_back import iit_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire block_t    head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           resid_valid,
    input  wire logic      resid_stall,
    output resid_row_t     resid
);

    row_idx_t    out_row_reg;
    row_idx_t    out_row_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    resid_row_t  out_reg;
    resid_row_t  row_val;
    quad_t       col [4];
    resid_quad_t col_res [4];
    logic        load;

    assign resid_valid = out_valid_reg;
    assign resid       = out_reg;

    // Load a new row when the queue holds a block and the output register is free or being taken
    assign load = !q_status.empty && (!out_valid_reg || !resid_stall);
    assign pop  = load && (out_row_reg == LAST_ROW);

    // Column pass on each column of the head block
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                col[j][i] = head[i][j];
            end
            col_res[j] = col_pass(col[j]);
        end
        row_val.resid_col0 = col_res[0][out_row_reg];
        row_val.resid_col1 = col_res[1][out_row_reg];
        row_val.resid_col2 = col_res[2][out_row_reg];
        row_val.resid_col3 = col_res[3][out_row_reg];
        row_val.row_last   = (out_row_reg == LAST_ROW);
    end

    // Advance the output row and the valid flag
    always_comb
    begin
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg && resid_stall;
        if (load)
        begin
            out_row_next   = out_row_reg + row_idx_t'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_row_reg   <= out_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= row_val;
        end
    end

endmodule

`default_nettype wire

### design/integer_inverse_transform_4x4.sv
// Top level of the 4x4 inverse integer transform: front, queue and back.
// Depends on iit_pkg, iit_front, iit_queue and iit_back.
//
//  port group  | dir | word         | handshake
//  coef        | in  | coef_row_t   | coef_valid / coef_stall
//  resid       | out | resid_row_t  | resid_valid / resid_stall
//
// Rows one to three are taken one per cycle; the fourth is taken when the
// two-block queue has room. The column pass emits one row per cycle from
// the head block while resid_stall is low; a steady stream sustains one
// word per cycle. Each block passes through a queue entry and then the
// output register. Reset clears counts, pointers and valid; stored data
// is not reset. Either side may stall at any time without loss.
`default_nettype none

module integer_inverse_transform_4x4 import iit_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      coef_valid,
    output logic           coef_stall,
    input  wire coef_row_t coef,
    output logic           resid_valid,
    input  wire logic      resid_stall,
    output resid_row_t     resid
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    block_t    push_data;
    block_t    head;

    iit_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef       (coef),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    iit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    iit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .resid_valid (resid_valid),
        .resid_stall (resid_stall),
        .resid       (resid)
    );

endmodule

`default_nettype wire

### design/iit_checker.sv
// Port-level checks for integer_inverse_transform_4x4, bound to the top level.
// Depends on iit_pkg.
`default_nettype none

module iit_checker import iit_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       coef_valid,
    input wire logic       coef_stall,
    input wire coef_row_t  coef,
    input wire logic       resid_valid,
    input wire logic       resid_stall,
    input wire resid_row_t resid
);

    row_idx_t in_cnt_reg;
    row_idx_t in_cnt_next;
    row_idx_t out_cnt_reg;
    row_idx_t out_cnt_next;

    // Track row position on each side
    always_comb
    begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        if (coef_valid && !coef_stall)
        begin
            in_cnt_next = in_cnt_reg + row_idx_t'(1);
        end
        if (resid_valid && !resid_stall)
        begin
            out_cnt_next = out_cnt_reg + row_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    // Only the closing row of a block may be held back
    a_stall_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        coef_stall |-> (in_cnt_reg == LAST_ROW))
        else $error("coef_stall raised on a row other than the fourth");

    // The last flag marks every fourth output word and no other
    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        (resid_valid && !resid_stall) |-> (resid.row_last == (out_cnt_reg == LAST_ROW)))
        else $error("row_last out of step with output row count");

    // A stalled output word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (resid_valid && resid_stall) |=> resid_valid)
        else $error("resid_valid dropped while stalled");

    // A stalled output word does not change
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (resid_valid && resid_stall) |=> $stable(resid))
        else $error("resid changed while stalled");

endmodule

bind integer_inverse_transform_4x4 iit_checker u_iit_checker (.*);

`default_nettype wire
